// ===== rtl/core/bbs_pkg.sv =====
// shared widths and codes for the bracketed binary search block
`default_nettype none

package bbs_pkg;

  // fixed widths of the word fields
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 64;

  // kind codes of an input word
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_DESC_MODE = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/bbs_if.sv =====
// request and response channel interfaces of the bracketed binary search block
`default_nettype none

interface bbs_req_if import bbs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic        [IDX_W-1:0] entry_index;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [VAL_W-1:0] query_key;
  logic        [IDX_W-1:0] bracket_low;
  logic        [POS_W-1:0] bracket_high;

  modport source (
    output valid, kind, entry_index, entry_value, query_key, bracket_low, bracket_high,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, entry_value, query_key, bracket_low, bracket_high,
    output ready
  );
endinterface

interface bbs_rsp_if import bbs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] found_index;

  modport source (output valid, found_index, input ready);
  modport sink   (input valid, found_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bracket_binary_search_top.sv =====
// bracketed binary search over a loaded signed fixed-point key table
// a load word writes one key and gives no result; a query passes idle, search and finish
//   steps, one search step per probe, at most ceil(log2(high - low)), 10 for a full bracket
// throughput: a query holds the block until the output register takes its result; one
//   probe per cycle on the key memory's single read port; finish waits while the output is full
// reset: async active low, clears the sequencer, output valid and descending_mode, not the keys
`default_nettype none

module bracket_binary_search_top import bbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bbs_req_if.sink                    req_i,
  bbs_rsp_if.source                  rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StFinish
  } state_e;

  state_e                      state_q;
  logic        [POS_W-1:0]     lo_q;
  logic        [POS_W-1:0]     hi_q;
  logic        [POS_W-1:0]     mid_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic                        mode_q;
  logic                        out_valid_q;
  logic        [IDX_W-1:0]     found_q;

  // key memory, one write and one registered read port
  logic        [KEY_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic        [KEY_WIDTH-1:0] rdata_q;
  logic                        rd_inrange_q;

  logic                        in_acc;
  logic                        is_query;
  logic                        is_load;
  logic        [POS_W-1:0]     start_lo;
  logic signed [KEY_WIDTH-1:0] probe;
  logic                        beyond;
  logic        [POS_W-1:0]     step_lo;
  logic        [POS_W-1:0]     step_hi;
  logic        [POS_W-1:0]     sel_lo;
  logic        [POS_W-1:0]     sel_hi;
  logic        [POS_W:0]       sum;
  logic        [POS_W-1:0]     sel_mid;
  logic                        more;
  logic                        rd_en;
  logic                        wr_en;
  logic                        out_free;
  logic                        out_load;
  logic                        cfg_wr;

  // ---------------------------------------------------------------------------
  // configuration port, writes land in the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_DESC_MODE);
  assign prdata = (paddr[2] == REG_DESC_MODE) ? CFG_DATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // word intake
  // ---------------------------------------------------------------------------
  assign req_i.ready = (state_q == StIdle);
  assign in_acc      = req_i.valid & req_i.ready;
  assign is_query    = in_acc & (req_i.kind == KIND_QUERY);
  assign is_load     = in_acc & (req_i.kind == KIND_LOAD);
  assign start_lo    = POS_W'(req_i.bracket_low);

  // ---------------------------------------------------------------------------
  // shared probe unit: compare the entry read last cycle, narrow the bracket
  // and issue the read at the new midpoint in the same cycle
  // ---------------------------------------------------------------------------
  // probes past the end of the table read as zero
  assign probe   = rd_inrange_q ? $signed(rdata_q) : '0;
  assign beyond  = mode_q ? (probe < key_q) : (probe > key_q);
  assign step_lo = beyond ? lo_q : mid_q;
  assign step_hi = beyond ? mid_q : hi_q;

  // at the start of a query the bracket comes straight from the request word
  assign sel_lo  = (state_q == StIdle) ? start_lo : step_lo;
  assign sel_hi  = (state_q == StIdle) ? req_i.bracket_high : step_hi;
  assign sum     = {1'b0, sel_lo} + {1'b0, sel_hi};
  assign sel_mid = sum[POS_W:1];
  // another probe while high exceeds low + 1
  assign more    = {1'b0, sel_hi} > ({1'b0, sel_lo} + (POS_W+1)'(1));

  assign rd_en = is_query | (state_q == StSearch);
  assign wr_en = is_load & (32'(req_i.entry_index) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(req_i.entry_index)] <= req_i.entry_value[KEY_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q      <= mem_q[AddrW'(sel_mid)];
      rd_inrange_q <= (32'(sel_mid) < TABLE_DEPTH);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  assign out_free = ~out_valid_q | rsp_o.ready;
  assign out_load = (state_q == StFinish) & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (is_query) begin
            lo_q    <= start_lo;
            hi_q    <= req_i.bracket_high;
            mid_q   <= sel_mid;
            key_q   <= $signed(req_i.query_key[KEY_WIDTH-1:0]);
            // empty or inverted bracket gives low unchanged
            state_q <= more ? StSearch : StFinish;
          end
        end
        StSearch: begin
          lo_q  <= step_lo;
          hi_q  <= step_hi;
          mid_q <= sel_mid;
          if (!more) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            found_q <= lo_q[IDX_W-1:0];
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found_index = found_q;

`ifndef SYNTH
  // the probed midpoint always lies strictly inside the bracket
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> ((lo_q < mid_q) && (mid_q < hi_q)))
    else $error("probe midpoint outside bracket");

  // a result appears only out of the finish step
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFinish))
    else $error("result raised outside finish step");

  // the finish step hands the final low to the output register
  a_result_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFinish) && out_free) |=>
      (out_valid_q && (found_q == $past(lo_q[IDX_W-1:0])) && (state_q == StIdle)))
    else $error("result does not match final low");
`endif

endmodule

`default_nettype wire

// ===== test/tb_bracket_binary_search_top.sv =====
// self-checking testbench for the bracketed binary search block, directed and random words
`timescale 1ns / 100ps

module tb_bracket_binary_search_top;
  import bbs_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // margin beyond the longest query, before config writes and at the end
  localparam int unsigned SETTLE      = 30;
  localparam logic [CFG_ADDR_W-1:0] DESC_MODE_ADDR = CFG_ADDR_W'(4 * REG_DESC_MODE);
  localparam logic signed [VAL_W-1:0] KEY_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] KEY_ONE = 64'sh0000_0001_0000_0000;

  // one request word as the block sees it
  typedef struct {
    logic                    kind;
    logic        [IDX_W-1:0] entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] query_key;
    logic        [IDX_W-1:0] bracket_low;
    logic        [POS_W-1:0] bracket_high;
  } search_word_t;

  // keeps its own key table and mode, predicts found_index per query
  class search_scoreboard;
    logic signed [VAL_W-1:0] key_table [DEPTH];
    logic                    descending;
    logic        [IDX_W-1:0] found_q [$];
    int unsigned             errors;

    function new();
      descending = 1'b0;
      errors     = 0;
    endfunction

    function void note_word(search_word_t w);
      int unsigned             lo;
      int unsigned             hi;
      int unsigned             mid;
      logic signed [VAL_W-1:0] probe;
      logic                    beyond;
      if (w.kind == KIND_LOAD) begin
        key_table[w.entry_index] = w.entry_value;
      end else begin
        lo = w.bracket_low;
        hi = w.bracket_high;
        while (hi > lo + 1) begin
          mid    = (hi + lo) / 2;
          probe  = key_table[mid];
          beyond = descending ? (probe < w.query_key) : (probe > w.query_key);
          if (beyond) hi = mid;
          else lo = mid;
        end
        found_q.push_back(IDX_W'(lo));
      end
    endfunction

    function void check_found(logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      if (found_q.size() == 0) begin
        $display("%0t: found_index expected none actual %0d", $time, got);
        errors++;
      end else begin
        want = found_q.pop_front();
        if (got !== want) begin
          $display("%0t: found_index expected %0d actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bbs_req_if req ();
  bbs_rsp_if rsp ();

  search_scoreboard sb = new();
  bit               no_idle = 1'b0;   // when set, neither side idles or stalls
  int unsigned      cycle_count = 0;

  bracket_binary_search_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run guard, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall per word, ready never dropped and raised in one step
  initial begin : result_sink
    int unsigned stall;
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp.valid && rsp.ready));
    end
  end

  // every accepted result goes against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_found(rsp.found_index);
  end

  function automatic logic signed [VAL_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // load word, unused query fields carry junk
  function automatic search_word_t load_word(int unsigned idx, logic signed [VAL_W-1:0] val);
    search_word_t w;
    w.kind         = KIND_LOAD;
    w.entry_index  = IDX_W'(idx);
    w.entry_value  = val;
    w.query_key    = rand_key();
    w.bracket_low  = IDX_W'($urandom);
    w.bracket_high = POS_W'($urandom);
    return w;
  endfunction

  // query word, unused load fields carry junk
  function automatic search_word_t query_word(logic signed [VAL_W-1:0] key, int unsigned lo,
                                              int unsigned hi);
    search_word_t w;
    w.kind         = KIND_QUERY;
    w.entry_index  = IDX_W'($urandom);
    w.entry_value  = rand_key();
    w.query_key    = key;
    w.bracket_low  = IDX_W'(lo);
    w.bracket_high = POS_W'(hi);
    return w;
  endfunction

  // drives one word after a random gap, notes it at the accepting edge
  task automatic send_word(input search_word_t w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.kind         <= w.kind;
    req.entry_index  <= w.entry_index;
    req.entry_value  <= w.entry_value;
    req.query_key    <= w.query_key;
    req.bracket_low  <= w.bracket_low;
    req.bracket_high <= w.bracket_high;
    do @(posedge clk_i); while (!req.ready);
    sb.note_word(w);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain_results();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (sb.found_q.size() != 0) @(negedge clk_i);
  endtask

  // idle the block, write descending_mode (junk in the upper bits), read it back
  task automatic set_mode(input logic mode);
    logic [CFG_DATA_W-1:0] data;
    drain_results();
    // loads give no result, so give the last one time to retire
    repeat (SETTLE) @(negedge clk_i);
    data    = $urandom;
    data[0] = mode;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DESC_MODE_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.descending = mode;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== mode) begin
      $display("%0t: descending_mode expected %0b actual %0b", $time, mode, prdata[0]);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one random phase: load a sorted region, then query inside it;
  // probes stay strictly inside the bracket, so probes never reach unwritten entries
  task automatic run_phase(input int unsigned phase_no, input logic mode);
    logic signed [VAL_W-1:0] vals [$];
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] tmp;
    int unsigned             size;
    int unsigned             base;
    int unsigned             lo0;
    int unsigned             lo;
    int unsigned             hi;
    int unsigned             pick;
    int unsigned             a;
    int unsigned             b;
    int unsigned             i;
    int unsigned             q;
    set_mode(mode);
    no_idle = (phase_no % 4 == 3);
    size = $urandom_range(2, 64);
    base = $urandom_range(0, DEPTH - size);
    // duplicates now and then so exact hits land on runs of equal keys
    for (i = 0; i < size; i++) begin
      if (i != 0 && $urandom_range(0, 3) == 0) vals.push_back(vals[i-1]);
      else vals.push_back(rand_key());
    end
    if (mode) vals.rsort();
    else vals.sort();
    // sometimes a broken table: two entries swapped
    if ($urandom_range(0, 7) == 0) begin
      a       = $urandom_range(0, size - 1);
      b       = $urandom_range(0, size - 1);
      tmp     = vals[a];
      vals[a] = vals[b];
      vals[b] = tmp;
    end
    for (i = 0; i < size; i++) send_word(load_word(base + i, vals[i]));

    lo0 = (base == 0) ? 0 : base - 1;
    for (q = 0; q < 45; q++) begin
      // hold-off mid-phase until the block has handed back everything
      if (phase_no == 1 && q == 40) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // empty, single-entry or inverted bracket anywhere, no probe happens
        lo = $urandom_range(0, DEPTH - 1);
        hi = $urandom_range(0, lo + 1);
        send_word(query_word(rand_key(), lo, hi));
      end else if (pick < 17) begin
        // stray reload inside the region, keeps it written but may break order
        send_word(load_word(base + $urandom_range(0, size - 1), rand_key()));
      end else begin
        if ($urandom_range(0, 1)) begin
          lo = lo0;
          hi = base + size;
        end else begin
          lo = $urandom_range(lo0, base + size - 1);
          hi = $urandom_range(lo, base + size);
        end
        case ($urandom_range(0, 3))
          0: key = rand_key();
          1: key = vals[$urandom_range(0, size - 1)];
          2: begin
            key = vals[$urandom_range(0, size - 1)];
            key = $urandom_range(0, 1) ? key + 1 : key - 1;
          end
          default: key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
        endcase
        send_word(query_word(key, lo, hi));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    rst_ni           <= 1'b0;
    req.valid        <= 1'b0;
    req.kind         <= KIND_LOAD;
    req.entry_index  <= '0;
    req.entry_value  <= '0;
    req.query_key    <= '0;
    req.bracket_low  <= '0;
    req.bracket_high <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: small ascending table with both key extremes, plus the top two entries
    set_mode(1'b0);
    send_word(load_word(0, KEY_MIN));
    send_word(load_word(1, -64'sd5));
    send_word(load_word(2, -64'sd1));
    send_word(load_word(3, 64'sd0));
    send_word(load_word(4, 64'sd1));
    send_word(load_word(5, KEY_ONE));
    send_word(load_word(6, 64'sh0000_0007_8000_0000));
    send_word(load_word(7, KEY_MAX));
    send_word(load_word(1022, 64'sd0));
    send_word(load_word(1023, KEY_MAX));
    send_word(query_word(KEY_MIN, 0, 8));
    send_word(query_word(KEY_MAX, 0, 8));
    send_word(query_word(64'sd0, 0, 8));
    send_word(query_word(-64'sd1, 0, 8));
    send_word(query_word(KEY_ONE + 1, 0, 8));
    // empty bracket, single-entry bracket at the top, inverted bracket
    send_word(query_word(KEY_MAX, 3, 3));
    send_word(query_word(KEY_MIN, 1023, 1024));
    send_word(query_word(64'sd0, 1023, 0));
    // brackets closed by the exclusive bound 1024
    send_word(query_word(KEY_MAX, 1021, 1024));
    send_word(query_word(-64'sd1, 1022, 1024));

    // random phases, both orders
    for (p = 0; p < 10; p++) run_phase(p, p[0]);

    drain_results();
    repeat (SETTLE) @(negedge clk_i);
    if (sb.errors == 0 && sb.found_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bbs_pkg.sv
rtl/core/bbs_if.sv
rtl/core/bracket_binary_search_top.sv
test/tb_bracket_binary_search_top.sv
